FILE: rtl/mecd_pkg.sv
// Shared types, constants and helper functions for the multi-encoding code point decoder.
package mecd_pkg;

    // Encoding select codes
    localparam logic [1:0] ENC_UTF8     = 2'd0;
    localparam logic [1:0] ENC_WIN1252  = 2'd1;
    localparam logic [1:0] ENC_UTF16LE  = 2'd2;
    localparam logic [1:0] ENC_UTF16BE  = 2'd3;

    // Input item kinds
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Input error classes
    localparam logic [1:0] CLS_NONE      = 2'd0;
    localparam logic [1:0] CLS_SURROGATE = 2'd1;
    localparam logic [1:0] CLS_NONCHAR   = 2'd2;
    localparam logic [1:0] CLS_CONTROL   = 2'd3;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00fffd;
    localparam logic [20:0] CP_LF          = 21'h00000a;
    localparam logic [20:0] CP_CR          = 21'h00000d;

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;

    // Code point candidate produced by the decode logic
    typedef struct packed {
        logic        valid;
        logic        eof;
        logic [20:0] cp;
        logic        err;
        logic [31:0] off;
    } cand_t;

    // Result item as stored in the output queue
    typedef struct packed {
        logic [20:0] cp;
        logic        eof;
        logic        err;
        logic [1:0]  cls;
        logic [31:0] off;
        logic        last;
    } result_t;

    // Result of passing a candidate through the line-break fold
    typedef struct packed {
        logic    valid;
        logic    prev_cr;
        result_t res;
    } emit_t;

    // Map 0x80..0x9f of windows-1252 to its code point
    function automatic logic [15:0] mecd_win1252_high(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'h20ac;
            5'd1:  v = 16'h0081;
            5'd2:  v = 16'h201a;
            5'd3:  v = 16'h0192;
            5'd4:  v = 16'h201e;
            5'd5:  v = 16'h2026;
            5'd6:  v = 16'h2020;
            5'd7:  v = 16'h2021;
            5'd8:  v = 16'h02c6;
            5'd9:  v = 16'h2030;
            5'd10: v = 16'h0160;
            5'd11: v = 16'h2039;
            5'd12: v = 16'h0152;
            5'd13: v = 16'h008d;
            5'd14: v = 16'h017d;
            5'd15: v = 16'h008f;
            5'd16: v = 16'h0090;
            5'd17: v = 16'h2018;
            5'd18: v = 16'h2019;
            5'd19: v = 16'h201c;
            5'd20: v = 16'h201d;
            5'd21: v = 16'h2022;
            5'd22: v = 16'h2013;
            5'd23: v = 16'h2014;
            5'd24: v = 16'h02dc;
            5'd25: v = 16'h2122;
            5'd26: v = 16'h0161;
            5'd27: v = 16'h203a;
            5'd28: v = 16'h0153;
            5'd29: v = 16'h009d;
            5'd30: v = 16'h017e;
            5'd31: v = 16'h0178;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Classify a code point after line-break folding
    function automatic logic [1:0] mecd_classify(input logic [20:0] cp);
        logic [1:0] cls;
        if (cp >= 21'h00d800 && cp <= 21'h00dfff) begin
            cls = CLS_SURROGATE;
        end else if ((cp >= 21'h00fdd0 && cp <= 21'h00fdef) || (cp[15:0] >= 16'hfffe)) begin
            cls = CLS_NONCHAR;
        end else if ((cp >= 21'd1 && cp <= 21'd8) || cp == 21'd11 ||
                     (cp >= 21'd14 && cp <= 21'd31) ||
                     (cp >= 21'd127 && cp <= 21'd159)) begin
            cls = CLS_CONTROL;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

    // Fold CR to LF, drop LF after CR, and tag the class
    function automatic emit_t mecd_emit(input cand_t c, input logic prev_cr);
        emit_t e;
        e = '0;
        e.prev_cr = prev_cr;
        if (c.valid) begin
            if (c.eof) begin
                e.valid   = 1'b1;
                e.prev_cr = 1'b0;
                e.res.eof = 1'b1;
                e.res.off = c.off;
            end else if (c.cp == CP_LF && prev_cr) begin
                e.prev_cr = 1'b0;
            end else begin
                e.valid   = 1'b1;
                e.prev_cr = (c.cp == CP_CR);
                e.res.cp  = (c.cp == CP_CR) ? CP_LF : c.cp;
                e.res.err = c.err;
                e.res.cls = mecd_classify(e.res.cp);
                e.res.off = c.off;
            end
        end
        return e;
    endfunction

endpackage

FILE: rtl/multi_encoding_code_point_decoder.sv
// Top level: byte stream to Unicode code point decoder (UTF-8, windows-1252, UTF-16).
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+---------------------------------------
//  s_        | in  | s_tvalid / s_tready       | tdata: byte_value, byte_offset; tuser: mode
//  m_        | out | m_tvalid / m_tready       | tdata: code_point .. source_offset;
//            |     |                           | tuser: end_marker; tlast: last
//  cfg_      | in  | cfg_valid / cfg_ready     | cfg_data: encoding_select
//
//  One input beat per cycle while the decode stage does not wait: the beat lands in an input
//  register, is decoded in one pass and its zero, one or two results go into a four-entry
//  result queue; the output port shows the queue head.
//  The decode stage waits while the queue holds more than two results, so input stalls
//  only when the sink stalls or items giving two results pile up.
//  Reset (aresetn low, synchronous) empties the queue and clears the decoder state.
//  The config channel is always ready; the encoding select is registered and applies to items decoded after the write.
module multi_encoding_code_point_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] byte_value, [39:8] byte_offset
    input  logic        s_tuser,   // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [20:0] code_point, [21] encoding_error,
                                   // [23:22] input_error_class, [55:24] source_offset
    output logic        m_tuser,   // [0] end_marker
    output logic        m_tlast,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // encoding_select
);

    localparam int QPW = $clog2(mecd_pkg::QUEUE_DEPTH);

    // Input register
    logic        in_valid_reg;
    logic        in_mode_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_off_reg;

    // Configuration
    logic [1:0]  enc_reg;

    // Decoder state
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        hs_valid_reg, hs_valid_next;
    logic [9:0]  hs_bits_reg, hs_bits_next;
    logic [31:0] surr_off_reg, surr_off_next;
    logic [31:0] seq_off_reg, seq_off_next;
    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  seen_reg, seen_next;
    logic [20:0] partial_reg, partial_next;
    logic [7:0]  min_reg, min_next;
    logic [7:0]  max_reg, max_next;
    logic        prev_cr_reg, prev_cr_next;
    logic        end_sent_reg, end_sent_next;

    // Result queue
    mecd_pkg::result_t   q_mem_reg [mecd_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]      q_wr_reg;
    logic [QPW-1:0]      q_rd_reg;
    logic [QPW:0]        q_cnt_reg;

    logic                s_accept;
    logic                m_accept;
    logic                proc;
    mecd_pkg::cand_t     c0, c1;
    mecd_pkg::emit_t     e0, e1;
    mecd_pkg::result_t   w0, w1;
    logic [1:0]          n_res;
    mecd_pkg::result_t   head;

    assign proc      = in_valid_reg && (q_cnt_reg <= (QPW+1)'(mecd_pkg::QUEUE_DEPTH - 2));
    assign s_tready  = !in_valid_reg || proc;
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // Decode one item into up to two candidates and the next state
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] cu;
        logic        lead;
        logic        rest;
        b               = in_byte_reg;
        lo              = 8'h80;
        hi              = 8'hbf;
        cu              = 16'h0000;
        lead            = 1'b1;
        rest            = 1'b1;
        c0              = '0;
        c1              = '0;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        hs_valid_next   = hs_valid_reg;
        hs_bits_next    = hs_bits_reg;
        surr_off_next   = surr_off_reg;
        seq_off_next    = seq_off_reg;
        needed_next     = needed_reg;
        seen_next       = seen_reg;
        partial_next    = partial_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        end_sent_next   = end_sent_reg;

        if (in_mode_reg == mecd_pkg::MODE_END) begin
            // Flush held state, then send EOF once
            if (!end_sent_reg) begin
                if (needed_reg != 2'd0 || hs_valid_reg || pend_valid_reg) begin
                    c0 = '{valid: 1'b1, eof: 1'b0, cp: mecd_pkg::CP_REPLACEMENT,
                           err: 1'b1, off: in_off_reg};
                end
                c1 = '{valid: 1'b1, eof: 1'b1, cp: 21'd0, err: 1'b0, off: in_off_reg};
                needed_next     = 2'd0;
                hs_valid_next   = 1'b0;
                pend_valid_next = 1'b0;
                pend_byte_next  = 8'h00;
                end_sent_next   = 1'b1;
            end
        end else if (enc_reg == mecd_pkg::ENC_WIN1252) begin
            // Single-byte table lookup
            c0.valid = 1'b1;
            c0.off   = in_off_reg;
            c0.cp    = (b[7:5] == 3'b100) ? {5'd0, mecd_pkg::mecd_win1252_high(b[4:0])}
                                          : {13'd0, b};
        end else if (enc_reg == mecd_pkg::ENC_UTF16LE || enc_reg == mecd_pkg::ENC_UTF16BE) begin
            if (!pend_valid_reg) begin
                // Hold the first byte of the code unit
                pend_valid_next = 1'b1;
                pend_byte_next  = b;
                seq_off_next    = in_off_reg;
            end else begin
                cu = (enc_reg == mecd_pkg::ENC_UTF16LE) ? {b, pend_byte_reg}
                                                        : {pend_byte_reg, b};
                pend_valid_next = 1'b0;
                pend_byte_next  = 8'h00;
                if (hs_valid_reg) begin
                    hs_valid_next = 1'b0;
                    c0.valid = 1'b1;
                    c0.off   = surr_off_reg;
                    if (cu[15:10] == 6'b110111) begin
                        // Pair the held high surrogate with this low one
                        c0.cp = 21'h010000 + {1'b0, hs_bits_reg, cu[9:0]};
                        rest  = 1'b0;
                    end else begin
                        c0.cp  = mecd_pkg::CP_REPLACEMENT;
                        c0.err = 1'b1;
                    end
                end
                if (rest) begin
                    if (cu[15:10] == 6'b110110) begin
                        hs_valid_next = 1'b1;
                        hs_bits_next  = cu[9:0];
                        surr_off_next = seq_off_reg;
                    end else if (cu[15:10] == 6'b110111) begin
                        c1 = '{valid: 1'b1, eof: 1'b0, cp: mecd_pkg::CP_REPLACEMENT,
                               err: 1'b1, off: seq_off_reg};
                    end else begin
                        c1 = '{valid: 1'b1, eof: 1'b0, cp: {5'd0, cu}, err: 1'b0,
                               off: seq_off_reg};
                    end
                end
            end
        end else begin
            // UTF-8: continuation byte check
            if (needed_reg != 2'd0) begin
                lo = (seen_reg != 2'd0) ? 8'h80 : min_reg;
                hi = (seen_reg != 2'd0) ? 8'hbf : max_reg;
                if (b >= lo && b <= hi) begin
                    partial_next = {partial_reg[14:0], b[5:0]};
                    seen_next    = seen_reg + 2'd1;
                    if (seen_next == needed_reg) begin
                        needed_next = 2'd0;
                        c0 = '{valid: 1'b1, eof: 1'b0, cp: partial_next, err: 1'b0,
                               off: seq_off_reg};
                    end
                    lead = 1'b0;
                end else begin
                    needed_next = 2'd0;
                    c0 = '{valid: 1'b1, eof: 1'b0, cp: mecd_pkg::CP_REPLACEMENT,
                           err: 1'b1, off: seq_off_reg};
                end
            end
            // UTF-8: lead byte
            if (lead) begin
                if (!b[7]) begin
                    c1 = '{valid: 1'b1, eof: 1'b0, cp: {13'd0, b}, err: 1'b0,
                           off: in_off_reg};
                end else begin
                    seen_next    = 2'd0;
                    min_next     = 8'h80;
                    max_next     = 8'hbf;
                    seq_off_next = in_off_reg;
                    if (b >= 8'hc2 && b <= 8'hdf) begin
                        needed_next  = 2'd1;
                        partial_next = {16'd0, b[4:0]};
                    end else if (b >= 8'he0 && b <= 8'hef) begin
                        needed_next  = 2'd2;
                        partial_next = {17'd0, b[3:0]};
                        if (b == 8'he0) begin
                            min_next = 8'ha0;
                        end
                        if (b == 8'hed) begin
                            max_next = 8'h9f;
                        end
                    end else if (b >= 8'hf0 && b <= 8'hf4) begin
                        needed_next  = 2'd3;
                        partial_next = {18'd0, b[2:0]};
                        if (b == 8'hf0) begin
                            min_next = 8'h90;
                        end
                        if (b == 8'hf4) begin
                            max_next = 8'h8f;
                        end
                    end else begin
                        c1 = '{valid: 1'b1, eof: 1'b0, cp: mecd_pkg::CP_REPLACEMENT,
                               err: 1'b1, off: in_off_reg};
                    end
                end
            end
        end
    end

    // Fold line breaks in order and pack the results
    always_comb begin
        e0           = mecd_pkg::mecd_emit(c0, prev_cr_reg);
        e1           = mecd_pkg::mecd_emit(c1, e0.prev_cr);
        prev_cr_next = e1.prev_cr;
        w0           = e0.res;
        w1           = e1.res;
        n_res        = {1'b0, e0.valid} + {1'b0, e1.valid};
        if (e0.valid && e1.valid) begin
            w1.last = 1'b1;
        end else if (e1.valid) begin
            w0      = e1.res;
            w0.last = 1'b1;
        end else begin
            w0.last = 1'b1;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_off_reg  <= s_tdata[39:8];
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_reg <= mecd_pkg::ENC_UTF8;
        end else if (cfg_valid && cfg_ready) begin
            enc_reg <= cfg_data;
        end
    end

    // Decoder state: advance on each decoded item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= 8'h00;
            hs_valid_reg   <= 1'b0;
            hs_bits_reg    <= 10'd0;
            surr_off_reg   <= 32'd0;
            seq_off_reg    <= 32'd0;
            needed_reg     <= 2'd0;
            seen_reg       <= 2'd0;
            partial_reg    <= 21'd0;
            min_reg        <= 8'h80;
            max_reg        <= 8'hbf;
            prev_cr_reg    <= 1'b0;
            end_sent_reg   <= 1'b0;
        end else if (proc) begin
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            hs_valid_reg   <= hs_valid_next;
            hs_bits_reg    <= hs_bits_next;
            surr_off_reg   <= surr_off_next;
            seq_off_reg    <= seq_off_next;
            needed_reg     <= needed_next;
            seen_reg       <= seen_next;
            partial_reg    <= partial_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            prev_cr_reg    <= prev_cr_next;
            end_sent_reg   <= end_sent_next;
        end
    end

    // Result queue: push up to two, pop one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (proc) begin
                q_wr_reg <= q_wr_reg + QPW'(n_res);
            end
            if (m_accept) begin
                q_rd_reg <= q_rd_reg + QPW'(1);
            end
            q_cnt_reg <= q_cnt_reg + (proc ? (QPW+1)'(n_res) : '0)
                         - (QPW+1)'(m_accept);
        end
        if (proc && n_res != 2'd0) begin
            q_mem_reg[q_wr_reg] <= w0;
        end
        if (proc && n_res == 2'd2) begin
            q_mem_reg[q_wr_reg + QPW'(1)] <= w1;
        end
    end

    // Drive the result beat from the queue head
    assign head     = q_mem_reg[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {head.off, head.cls, head.err, head.cp};
    assign m_tuser  = head.eof;
    assign m_tlast  = head.last;

endmodule

FILE: rtl/mecd_checker.sv
// Port-level checker for the code point decoder and its bind to the top level.
module mecd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // The end marker is always the final result of its item
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end marker without tlast");

    // The end marker carries no code point, error flag or class
    a_eof_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[23:0] == 24'd0))
        else $error("end marker with nonzero payload");

    // An encoding error always shows the replacement character
    a_err_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[21] |-> (m_tdata[20:0] == mecd_pkg::CP_REPLACEMENT))
        else $error("encoding error without U+FFFD");

    // CR never leaves the block unfolded
    a_no_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[20:0] != mecd_pkg::CP_CR))
        else $error("CR seen on output");

endmodule

bind multi_encoding_code_point_decoder mecd_checker u_mecd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
